/* hw/rtl/egbd_pkg.sv */
// Exp-Golomb bit decoder package: codeword record type, kind codes and map tables.
// Shared by the front, queue, back and top-level modules. No dependencies.
package egbd_pkg;

	localparam int MAP_ENTRIES = 48;
	localparam int N_W         = 5;
	localparam int K_W         = 5;
	localparam int SUFFIX_W    = 32;
	localparam int VALUE_W     = 33;

	localparam logic [2:0] KIND_UE   = 3'd0;
	localparam logic [2:0] KIND_SE   = 3'd1;
	localparam logic [2:0] KIND_ME0  = 3'd2;
	localparam logic [2:0] KIND_ME1  = 3'd3;
	localparam logic [2:0] KIND_TE   = 3'd4;
	localparam logic [2:0] KIND_RICE = 3'd5;

	typedef struct packed {
		logic                direct;
		logic                err;
		logic [2:0]          kind;
		logic [N_W-1:0]      n;
		logic [K_W-1:0]      k;
		logic [SUFFIX_W-1:0] s;
	} rec_t;

	localparam logic [5:0] MAP0 [MAP_ENTRIES] = '{
		6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
		6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
		6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
		6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
		6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
		6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
	};

	localparam logic [5:0] MAP1 [MAP_ENTRIES] = '{
		6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
		6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
		6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
		6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
		6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
		6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41
	};

endpackage

/* hw/rtl/exp_golomb_bit_decoder_unit.sv */
// Exp-Golomb / Golomb-Rice bit-serial decoder, top level.
// Instantiates egbd_front, egbd_queue and egbd_back; depends on egbd_pkg.
//
// Input channel (in_valid/in_ready) takes one bitstream bit per request, MSB
// first, with req_type, te_multi and rice_k sampled at the first bit of each
// codeword. Output channel (out_valid/out_ready) delivers one request holding
// value and error per finished codeword; error results carry a value of zero.
// Throughput: one input bit per cycle while in_ready is high. The front parser
// handles a bit in the cycle it is accepted and pushes a record into a
// two-entry queue; the back builds the value into the output register, and
// out_valid rises when a codeword's value is loaded there. When the receiver
// stalls, the output register holds, the queue fills and in_ready drops once
// both queue entries are taken; up to three results can be buffered. Reset
// returns the parser to the start of a codeword and empties the queue and
// output register.
module exp_golomb_bit_decoder_unit #(
	parameter int MAX_PREFIX = 31,
	parameter int MAX_RICE_K = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               bit_in,
	input  logic [2:0]         req_type,
	input  logic               te_multi,
	input  logic [4:0]         rice_k,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [32:0] value,
	output logic               error
);

	logic           push_valid, push_ready, pop_valid, pop_ready;
	egbd_pkg::rec_t push_rec, pop_rec;

	assign in_ready = push_ready;

	egbd_front #(
		.MAX_PREFIX (MAX_PREFIX),
		.MAX_RICE_K (MAX_RICE_K)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_valid && in_ready),
		.bit_in     (bit_in),
		.req_type   (req_type),
		.te_multi   (te_multi),
		.rice_k     (rice_k),
		.push_valid (push_valid),
		.push_rec   (push_rec)
	);

	egbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec)
	);

	egbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_rec   (pop_rec),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.error     (error)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> value == '0)
		else $error("error result with nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pop_valid && out_valid)
		else $error("input stalled with the output register empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> in_valid && in_ready)
		else $error("record pushed without an accepted bit");

endmodule

/* hw/rtl/egbd_front.sv */
// Exp-Golomb bit decoder front: bit-serial prefix/suffix parser.
// Emits one egbd_pkg::rec_t per finished codeword. Depends on egbd_pkg.
module egbd_front #(
	parameter int MAX_PREFIX = 31,
	parameter int MAX_RICE_K = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 bit_in,
	input  logic [2:0]           req_type,
	input  logic                 te_multi,
	input  logic [4:0]           rice_k,
	output logic                 push_valid,
	output egbd_pkg::rec_t       push_rec
);

	localparam int ZW = $clog2(MAX_PREFIX + 1);
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_PREFIX = 2'd1;
	localparam logic [1:0] PH_SUFFIX = 2'd2;

	logic [1:0]                      phase_q, phase_d;
	logic [ZW-1:0]                   zc_q, zc_d, zc_w;
	logic [egbd_pkg::N_W-1:0]        left_q, left_d, left_w;
	logic [egbd_pkg::SUFFIX_W-1:0]   acc_q, acc_d;
	logic [2:0]                      kind_q, kind_d;
	logic [egbd_pkg::K_W-1:0]        k_q, k_d;
	logic                            start;

	always_comb begin
		phase_d    = phase_q;
		zc_d       = zc_q;
		left_d     = left_q;
		acc_d      = acc_q;
		kind_d     = kind_q;
		k_d        = k_q;
		push_valid = 1'b0;
		push_rec   = '0;
		start      = (phase_q != PH_PREFIX) && (phase_q != PH_SUFFIX);
		zc_w       = start ? '0 : zc_q;
		left_w     = '0;
		if (accept) begin
			if (start) begin
				kind_d = req_type;
				k_d    = (rice_k > egbd_pkg::K_W'(MAX_RICE_K)) ?
					egbd_pkg::K_W'(MAX_RICE_K) : rice_k;
				zc_d   = '0;
				left_d = '0;
				acc_d  = '0;
			end
			push_rec.kind = kind_d;
			push_rec.k    = k_d;
			push_rec.n    = egbd_pkg::N_W'(zc_w);
			if (start && req_type == egbd_pkg::KIND_TE && !te_multi) begin
				push_valid      = 1'b1;
				push_rec.direct = 1'b1;
				push_rec.s      = egbd_pkg::SUFFIX_W'(!bit_in);
				phase_d         = PH_IDLE;
			end else if (start || phase_q == PH_PREFIX) begin
				if (!bit_in) begin
					if (zc_w >= ZW'(MAX_PREFIX)) begin
						push_valid      = 1'b1;
						push_rec.direct = 1'b1;
						push_rec.err    = 1'b1;
						phase_d         = PH_IDLE;
					end else begin
						zc_d    = zc_w + 1'b1;
						phase_d = PH_PREFIX;
					end
				end else begin
					left_w = (kind_d == egbd_pkg::KIND_RICE) ? k_d : egbd_pkg::N_W'(zc_w);
					if (left_w == '0) begin
						push_valid = 1'b1;
						push_rec.s = '0;
						phase_d    = PH_IDLE;
					end else begin
						left_d  = left_w;
						phase_d = PH_SUFFIX;
					end
				end
			end else begin
				acc_d      = {acc_q[egbd_pkg::SUFFIX_W-2:0], bit_in};
				left_d     = left_q - 1'b1;
				push_rec.s = acc_d;
				if (left_d == '0) begin
					push_valid = 1'b1;
					phase_d    = PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			zc_q    <= '0;
			left_q  <= '0;
			acc_q   <= '0;
			kind_q  <= '0;
			k_q     <= '0;
		end else begin
			phase_q <= phase_d;
			zc_q    <= zc_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			kind_q  <= kind_d;
			k_q     <= k_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("front phase reached unused code");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SUFFIX |-> left_q != '0)
		else $error("suffix phase with no bits left");

	assert property (@(posedge clk) disable iff (!arst_n)
		zc_q <= ZW'(MAX_PREFIX))
		else $error("prefix count beyond limit");

endmodule

/* hw/rtl/egbd_queue.sv */
// Exp-Golomb bit decoder record queue: two-entry FIFO between front and back.
// Carries egbd_pkg::rec_t. Depends on egbd_pkg.
module egbd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  egbd_pkg::rec_t push_rec,
	output logic           pop_valid,
	input  logic           pop_ready,
	output egbd_pkg::rec_t pop_rec
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	egbd_pkg::rec_t    mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	logic              do_push, do_pop;

	assign push_ready = cnt_q != (AW+1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_rec    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

/* hw/rtl/egbd_back.sv */
// Exp-Golomb bit decoder back: value reconstruction and output register.
// Takes egbd_pkg::rec_t from the queue. Depends on egbd_pkg.
module egbd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  egbd_pkg::rec_t                      pop_rec,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [egbd_pkg::VALUE_W-1:0] value,
	output logic                                error
);

	localparam int VW = egbd_pkg::VALUE_W;

	logic          vld_q;
	logic [VW-1:0] val_q, val_d;
	logic          err_q, err_d;
	logic [VW-1:0] s_ext, pow2, code, sev, mag, rice;

	assign pop_ready = !vld_q || out_ready;

	always_comb begin
		s_ext = VW'(pop_rec.s);
		pow2  = VW'(1) << pop_rec.n;
		code  = pow2 - VW'(1) + s_ext;
		sev   = pow2 | s_ext;
		mag   = {1'b0, sev[VW-1:1]};
		rice  = (VW'(pop_rec.n) << pop_rec.k) | s_ext;
		err_d = 1'b0;
		val_d = code;
		if (pop_rec.direct) begin
			err_d = pop_rec.err;
			val_d = pop_rec.err ? '0 : s_ext;
		end else begin
			unique case (pop_rec.kind)
				egbd_pkg::KIND_RICE: val_d = rice;
				egbd_pkg::KIND_SE:   val_d = sev[0] ? (~mag + VW'(1)) : mag;
				egbd_pkg::KIND_ME0, egbd_pkg::KIND_ME1: begin
					if (code >= VW'(egbd_pkg::MAP_ENTRIES)) begin
						err_d = 1'b1;
						val_d = '0;
					end else if (pop_rec.kind == egbd_pkg::KIND_ME0) begin
						val_d = VW'(egbd_pkg::MAP0[code[5:0]]);
					end else begin
						val_d = VW'(egbd_pkg::MAP1[code[5:0]]);
					end
				end
				default: val_d = code;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			val_q <= val_d;
			err_q <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop_ready) begin
			vld_q <= pop_valid;
		end
	end

	assign out_valid = vld_q;
	assign value     = val_q;
	assign error     = err_q;

endmodule
